FILE: rtl/core/rlfe_pkg.sv
// Package for the RGB LED fade engine: sizes, word types, controller state
// and the command and status bundles. No dependencies.
package rlfe_pkg;

	localparam int NUM_LEDS      = 16;
	localparam int IDX_W         = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int OUT_IDX_W     = 6;
	localparam int COLOR_W       = 8;
	localparam int NUM_CH        = 3;
	localparam int CNT_W         = 16;
	localparam int PER_W         = 10;
	localparam int BRIGHT_W      = 16;
	localparam int BRIGHT_SHIFT  = 10;
	localparam int PROD_W        = COLOR_W + BRIGHT_W;
	localparam int DIV_W         = 16;
	localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
	localparam int DIV_STEPS     = DIV_W;
	localparam int DIV_SHORT     = COLOR_W;

	localparam logic [PER_W-1:0]   PER_RESET = PER_W'(10);
	localparam logic [COLOR_W-1:0] COLOR_MAX = {COLOR_W{1'b1}};

	localparam logic MODE_SET  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Channel order inside a color: red, green, blue.
	typedef logic [NUM_CH-1:0][COLOR_W-1:0] rgb_t;

	typedef struct packed {
		logic                mode;
		logic [7:0]          led_index;
		logic [COLOR_W-1:0]  red_in;
		logic [COLOR_W-1:0]  green_in;
		logic [COLOR_W-1:0]  blue_in;
		logic [BRIGHT_W-1:0] brightness;
		logic [CNT_W-1:0]    fade_time_ms;
	} in_word_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] out_index;
		logic [COLOR_W-1:0]   red_out;
		logic [COLOR_W-1:0]   green_out;
		logic [COLOR_W-1:0]   blue_out;
		logic                 changed;
		logic                 refresh;
		logic                 last;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SET_DIV,
		ST_TICK_RD,
		ST_TICK_GO,
		ST_TICK_DIV,
		ST_TICK_WB
	} ctl_state_t;

	typedef struct packed {
		logic take;         // latch the input word
		logic div_start;    // launch the dividers
		logic div_short;    // per-channel step division instead of fade division
		logic set_now;      // write target and current, clear countdown
		logic set_div;      // write target and divided countdown
		logic tick_read;    // fetch the LED under the walk pointer
		logic tick_commit;  // write back the LED and load the output register
	} ctl_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic idx_ok;
		logic fade_zero;
		logic div_busy;
		logic last_led;
		logic out_free;
	} ctl_stat_t;

endpackage

FILE: rtl/core/rlfe_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rlfe_pkg for widths and step counts.
module rlfe_div import rlfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             short_op,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             busy,
	output logic [DIV_W-1:0] quotient
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dq_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;
	logic                 fits;

	always_comb begin
		trial = {rem_q, dq_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= short_op ? DIV_CNT_W'(DIV_SHORT) : DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The dividend walks out of the top of dq_q while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

FILE: rtl/core/rlfe_datapath.sv
// Datapath of the fade engine: LED stores, brightness scaling, dividers,
// stepping logic and the output register. Depends on rlfe_pkg and rlfe_div.
module rlfe_datapath import rlfe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [PER_W-1:0]   cfg_wdata,
	input  in_word_t           in_word,
	input  logic               out_ready,
	output logic               out_valid,
	output out_word_t          out_word,
	input  ctl_cmd_t           cmd,
	output ctl_stat_t          stat
);

	logic [PER_W-1:0]  per_q;
	rgb_t              cur_q [NUM_LEDS];
	rgb_t              tgt_q [NUM_LEDS];
	logic [CNT_W-1:0]  cnt_q [NUM_LEDS];

	logic              mode_q;
	logic [7:0]        set_idx_q;
	logic [CNT_W-1:0]  fade_q;
	rgb_t              new_tgt_q;
	logic [IDX_W-1:0]  walk_q;
	logic              any_q;
	rgb_t              rd_cur_q;
	rgb_t              rd_tgt_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	rgb_t              req;
	rgb_t              scaled;
	logic [PROD_W-1:0] prod [NUM_CH];
	logic [PER_W-1:0]  per_eff;
	logic [IDX_W-1:0]  set_addr;
	logic [DIV_W-1:0]  dvd [NUM_CH];
	logic [DIV_W-1:0]  dvs [NUM_CH];
	logic [DIV_W-1:0]  quo [NUM_CH];
	logic [NUM_CH-1:0] busy;
	rgb_t              mag;
	rgb_t              step_col;
	rgb_t              next_col;
	logic              chg;
	logic [CNT_W-1:0]  next_cnt;
	logic [CNT_W-1:0]  fade_ticks;
	logic              out_free;
	logic              last_led;

	assign req      = {in_word.blue_in, in_word.green_in, in_word.red_in};
	assign per_eff  = (per_q == '0) ? PER_W'(1) : per_q;
	assign set_addr = set_idx_q[IDX_W-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign last_led = (walk_q == IDX_W'(NUM_LEDS - 1));

	// Brightness scaling and saturation, one small multiplier per channel.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod[c]   = PROD_W'(req[c]) * PROD_W'(in_word.brightness);
			scaled[c] = (|prod[c][PROD_W-1:BRIGHT_SHIFT+COLOR_W]) ? COLOR_MAX
				: prod[c][BRIGHT_SHIFT +: COLOR_W];
		end
	end

	// Channel magnitudes and divider operands. Lane 0 also divides the fade time.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			mag[c] = (rd_tgt_q[c] > rd_cur_q[c]) ? rd_tgt_q[c] - rd_cur_q[c]
				: rd_cur_q[c] - rd_tgt_q[c];
			dvd[c] = {mag[c], {(DIV_W-COLOR_W){1'b0}}};
			dvs[c] = rd_cnt_q;
		end
		if (!cmd.div_short) begin
			dvd[0] = fade_q;
			dvs[0] = DIV_W'(per_eff);
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_div
		rlfe_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (cmd.div_start),
			.short_op (cmd.div_short),
			.dividend (dvd[c]),
			.divisor  (dvs[c]),
			.busy     (busy[c]),
			.quotient (quo[c])
		);
	end

	assign fade_ticks = (quo[0] == '0) ? CNT_W'(1) : quo[0];

	// One tick step for the LED held in the read registers.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			step_col[c] = (quo[c][COLOR_W-1:0] == '0) ? COLOR_W'(1) : quo[c][COLOR_W-1:0];
		end
		next_col = rd_cur_q;
		next_cnt = rd_cnt_q;
		chg      = 1'b0;
		if (rd_cnt_q != '0) begin
			chg      = 1'b1;
			next_cnt = rd_cnt_q - 1'b1;
			for (int c = 0; c < NUM_CH; c++) begin
				if (rd_tgt_q[c] > rd_cur_q[c]) begin
					next_col[c] = rd_cur_q[c] + step_col[c];
				end else if (rd_tgt_q[c] < rd_cur_q[c]) begin
					next_col[c] = rd_cur_q[c] - step_col[c];
				end
			end
		end else if (rd_cur_q != rd_tgt_q) begin
			chg      = 1'b1;
			next_col = rd_tgt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q <= PER_RESET;
		end else if (cfg_we) begin
			per_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				cur_q[i] <= '0;
				tgt_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (cmd.set_now) begin
			cur_q[set_addr] <= new_tgt_q;
			tgt_q[set_addr] <= new_tgt_q;
			cnt_q[set_addr] <= '0;
		end else if (cmd.set_div) begin
			tgt_q[set_addr] <= new_tgt_q;
			cnt_q[set_addr] <= fade_ticks;
		end else if (cmd.tick_commit) begin
			cur_q[walk_q] <= next_col;
			cnt_q[walk_q] <= next_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q      <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				walk_q <= '0;
				any_q  <= 1'b0;
			end else if (cmd.tick_commit) begin
				any_q <= any_q | chg;
				if (!last_led) begin
					walk_q <= walk_q + 1'b1;
				end
			end
			if (cmd.tick_commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q    <= in_word.mode;
			set_idx_q <= in_word.led_index;
			fade_q    <= in_word.fade_time_ms;
			new_tgt_q <= scaled;
		end
		if (cmd.tick_read) begin
			rd_cur_q <= cur_q[walk_q];
			rd_tgt_q <= tgt_q[walk_q];
			rd_cnt_q <= cnt_q[walk_q];
		end
		if (cmd.tick_commit) begin
			out_word_q.out_index <= OUT_IDX_W'(walk_q);
			out_word_q.red_out   <= next_col[0];
			out_word_q.green_out <= next_col[1];
			out_word_q.blue_out  <= next_col[2];
			out_word_q.changed   <= chg;
			out_word_q.refresh   <= last_led && (any_q || chg);
			out_word_q.last      <= last_led;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_comb begin
		stat.is_tick   = (mode_q == MODE_TICK);
		stat.idx_ok    = (set_idx_q < 8'(NUM_LEDS));
		stat.fade_zero = (fade_q == '0);
		stat.div_busy  = |busy;
		stat.last_led  = last_led;
		stat.out_free  = out_free;
	end

	ap_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_commit |-> out_free)
		else $error("LED committed while the output register is still full");

	ap_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.last |-> out_word_q.out_index == OUT_IDX_W'(NUM_LEDS - 1))
		else $error("final word of a tick does not report the last LED");

	ap_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(busy) |-> busy == '0)
		else $error("divider lanes fell out of step");

endmodule

FILE: rtl/core/rlfe_ctrl.sv
// Controller of the fade engine: sequences set items and the LED walk of a tick.
// Depends on rlfe_pkg for the state, command and status types.
module rlfe_ctrl import rlfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.is_tick) begin
					state_d = ST_TICK_RD;
				end else if (!stat.idx_ok) begin
					state_d = ST_IDLE;
				end else if (stat.fade_zero) begin
					cmd.set_now = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_SET_DIV;
				end
			end
			ST_SET_DIV: begin
				if (!stat.div_busy) begin
					cmd.set_div = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_TICK_RD: begin
				cmd.tick_read = 1'b1;
				state_d       = ST_TICK_GO;
			end
			ST_TICK_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_short = 1'b1;
				state_d       = ST_TICK_DIV;
			end
			ST_TICK_DIV: begin
				cmd.div_short = 1'b1;
				if (!stat.div_busy) begin
					state_d = ST_TICK_WB;
				end
			end
			ST_TICK_WB: begin
				cmd.div_short = 1'b1;
				if (stat.out_free) begin
					cmd.tick_commit = 1'b1;
					state_d         = stat.last_led ? ST_IDLE : ST_TICK_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while still busy");

	ap_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.div_busy)
		else $error("new word offered while a division is in flight");

	ap_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> stat.div_busy)
		else $error("divider did not start on command");

endmodule

FILE: rtl/core/rgb_led_fade_engine_top.sv
// Top level of the RGB LED fade engine: controller plus datapath.
// Depends on rlfe_pkg, rlfe_ctrl, rlfe_datapath and rlfe_div.
//
//   Channel  Handshake             Payload     Direction
//   in       in_valid / in_ready   in_word     into the block
//   out      out_valid / out_ready out_word    out of the block
//   cfg      cfg_we                cfg_wdata   into the block, no wait
//
// A set word is written straight from decode when the fade time is zero, and
// otherwise once the fade time is divided by the tick period in the bit-serial
// divider. A tick word walks every LED in turn: a read, an eight-step
// per-channel division of the gap by the ticks left, and a write-back. Reset
// is asynchronous and active low and clears every LED store and the controller
// at once; no clearing pass follows. A stall on the output only holds the walk
// at the write-back of the next LED, while the waiting word sits in the output
// register.
module rgb_led_fade_engine_top import rlfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [PER_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_word
);

	// The controller and the datapath talk only through these two bundles.
	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// The controller owns the input handshake: a word is taken only when the
	// block is idle, and one word is processed to its end before the next.
	rlfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the LED stores, the tick period register, the three
	// divider lanes and the output register.
	rlfe_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_word   (in_word),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_word  (out_word),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

FILE: tb/sv/tb_rgb_led_fade_engine_top.sv
// Self-checking testbench for rgb_led_fade_engine_top: a directed table followed by random
// set and tick words over several tick periods, checked against a behavioral fade predictor.
// Depends on rlfe_pkg and the engine RTL only.
`timescale 1ns / 100ps

module tb_rgb_led_fade_engine_top;
	import rlfe_pkg::*;

	// Generous bound on the whole run.
	localparam int CYCLE_LIMIT  = 500000;
	// A tick walks every LED in turn. The settle wait covers any word
	// still in flight once the last expected color has come out.
	localparam int SETTLE       = 4 * (2 + 12 * NUM_LEDS);
	localparam int RAND_PER_PH  = 63;
	localparam int NUM_PHASES   = 7;
	localparam int IDLE_PCT     = 36;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [PER_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_word_t         in_word = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_word_t        out_word;

	rgb_led_fade_engine_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// Shadow copy of the engine's LED stores and its one register. Every store is cleared
	// by reset, and the tick period comes up at its reset value.
	logic [COLOR_W-1:0] cur_lvl [NUM_LEDS][NUM_CH] = '{default: '0};
	logic [COLOR_W-1:0] tgt_lvl [NUM_LEDS][NUM_CH] = '{default: '0};
	logic [CNT_W-1:0]   ticks_left [NUM_LEDS] = '{default: '0};
	logic [PER_W-1:0]   tick_per = PER_RESET;

	// Colors the engine still owes us, oldest first.
	out_word_t colors_due [$];

	// Directed table: the word to send, and for some tick rows the final word of that tick
	// typed in by hand.
	in_word_t  dir_word [$];
	bit        dir_known [$];
	out_word_t dir_tail [$];

	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	bit          no_gaps = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Brightness scaling: the product keeps its upper bits from bit ten on and saturates.
	function automatic logic [COLOR_W-1:0] scale_level(logic [COLOR_W-1:0] lvl,
		logic [BRIGHT_W-1:0] br);
		logic [PROD_W-1:0] prod;
		prod = lvl * br;
		prod = prod >> BRIGHT_SHIFT;
		return (prod > PROD_W'(COLOR_MAX)) ? COLOR_MAX : prod[COLOR_W-1:0];
	endfunction

	// One linear step toward the target: the gap divided by the ticks left, truncated,
	// but never less than a single level.
	function automatic logic [COLOR_W-1:0] step_toward(logic [COLOR_W-1:0] cur,
		logic [COLOR_W-1:0] tgt, logic [CNT_W-1:0] n);
		logic [COLOR_W-1:0] gap;
		logic [CNT_W-1:0]   stp;
		if (n == '0 || cur == tgt)
			return tgt;
		gap = (tgt > cur) ? tgt - cur : cur - tgt;
		stp = CNT_W'(gap) / n;
		if (stp == '0)
			stp = CNT_W'(1);
		return (tgt > cur) ? cur + stp[COLOR_W-1:0] : cur - stp[COLOR_W-1:0];
	endfunction

	// Applies one accepted word to the shadow stores. A tick queues one color per LED.
	task automatic advance_leds(input in_word_t w);
		logic [CNT_W-1:0]   per;
		logic [CNT_W-1:0]   cnt;
		logic [COLOR_W-1:0] lvl_in [NUM_CH];
		logic               chg;
		logic               any;
		logic               differs;
		out_word_t          o;
		int                 idx;
		per = (tick_per == '0) ? CNT_W'(1) : CNT_W'(tick_per);
		lvl_in[0] = w.red_in;
		lvl_in[1] = w.green_in;
		lvl_in[2] = w.blue_in;
		if (w.mode == MODE_SET) begin
			// An index past the last LED leaves every store alone.
			if (w.led_index < NUM_LEDS) begin
				idx = int'(w.led_index);
				for (int ch = 0; ch < NUM_CH; ch++)
					tgt_lvl[idx][ch] = scale_level(lvl_in[ch], w.brightness);
				if (w.fade_time_ms == '0) begin
					for (int ch = 0; ch < NUM_CH; ch++)
						cur_lvl[idx][ch] = tgt_lvl[idx][ch];
					ticks_left[idx] = '0;
				end else begin
					cnt = w.fade_time_ms / per;
					ticks_left[idx] = (cnt == '0) ? CNT_W'(1) : cnt;
				end
			end
		end else begin
			any = 1'b0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				chg = 1'b0;
				differs = 1'b0;
				for (int ch = 0; ch < NUM_CH; ch++)
					differs |= (cur_lvl[i][ch] != tgt_lvl[i][ch]);
				if (ticks_left[i] != '0) begin
					// A running fade counts as a change even when already on target.
					for (int ch = 0; ch < NUM_CH; ch++)
						cur_lvl[i][ch] = step_toward(cur_lvl[i][ch], tgt_lvl[i][ch],
							ticks_left[i]);
					ticks_left[i] = ticks_left[i] - 1'b1;
					chg = 1'b1;
				end else if (differs) begin
					// Countdown spent but color off target: snap to it.
					for (int ch = 0; ch < NUM_CH; ch++)
						cur_lvl[i][ch] = tgt_lvl[i][ch];
					chg = 1'b1;
				end
				any |= chg;
				o.out_index = OUT_IDX_W'(i);
				o.red_out   = cur_lvl[i][0];
				o.green_out = cur_lvl[i][1];
				o.blue_out  = cur_lvl[i][2];
				o.changed   = chg;
				o.last      = (i == NUM_LEDS - 1);
				o.refresh   = o.last ? any : 1'b0;
				colors_due.push_back(o);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Word builders for the directed table
	// ------------------------------------------------------------------

	function automatic in_word_t set_word(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
		logic [7:0] b, logic [BRIGHT_W-1:0] br, logic [CNT_W-1:0] fade);
		in_word_t w;
		w.mode         = MODE_SET;
		w.led_index    = idx;
		w.red_in       = r;
		w.green_in     = g;
		w.blue_in      = b;
		w.brightness   = br;
		w.fade_time_ms = fade;
		return w;
	endfunction

	function automatic in_word_t tick_word();
		in_word_t w;
		w      = '0;
		w.mode = MODE_TICK;
		return w;
	endfunction

	// The final word of a tick: always the last LED, with the last flag set.
	function automatic out_word_t tick_tail(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic chg, logic refr);
		out_word_t o;
		o.out_index = OUT_IDX_W'(NUM_LEDS - 1);
		o.red_out   = r;
		o.green_out = g;
		o.blue_out  = b;
		o.changed   = chg;
		o.refresh   = refr;
		o.last      = 1'b1;
		return o;
	endfunction

	task automatic add_row(input in_word_t w, input bit known, input out_word_t tail);
		dir_word.push_back(w);
		dir_known.push_back(known);
		dir_tail.push_back(tail);
	endtask

	// Random word: mostly sets on real LEDs, a quarter ticks, and now and then an index
	// past the end. Brightness and fade time lean toward their interesting corners.
	function automatic in_word_t random_word();
		in_word_t w;
		w.red_in    = COLOR_W'($urandom);
		w.green_in  = COLOR_W'($urandom);
		w.blue_in   = COLOR_W'($urandom);
		w.led_index = ($urandom_range(9) == 0) ? 8'($urandom_range(255, NUM_LEDS))
		                                       : 8'($urandom_range(NUM_LEDS - 1));
		case ($urandom_range(4))
			0:       w.brightness = BRIGHT_W'($urandom);
			1:       w.brightness = BRIGHT_W'($urandom_range(1023));
			2:       w.brightness = BRIGHT_W'(1024);
			3:       w.brightness = '1;
			default: w.brightness = BRIGHT_W'($urandom_range(2047, 512));
		endcase
		case ($urandom_range(4))
			0:       w.fade_time_ms = '0;
			1:       w.fade_time_ms = CNT_W'($urandom_range(200, 1));
			2:       w.fade_time_ms = CNT_W'($urandom_range(5000, 200));
			3:       w.fade_time_ms = '1;
			default: w.fade_time_ms = CNT_W'($urandom);
		endcase
		w.mode = ($urandom_range(99) < 25) ? MODE_TICK : MODE_SET;
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Presents one word, idling first at random, and holds it until the engine takes it.
	// The predictor sees the word at the edge where it is accepted.
	task automatic send_word(input in_word_t w);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_leds(w);
	endtask

	// Lets every owed color drain, waits out any set word still in flight, then writes the
	// tick period while the engine sits idle.
	task automatic write_period(input logic [PER_W-1:0] per);
		in_valid <= 1'b0;
		while (colors_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= per;
		@(posedge clk);
		tick_per = per;
		cfg_we   <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// The sink drops ready at random, except during the no-idle stretch.
	always @(posedge clk)
		out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);

	function automatic void cmp_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endfunction

	// Each accepted color word is matched against the oldest owed one, field by field.
	always @(posedge clk) begin : color_check
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (colors_due.size() == 0) begin
				$error("out_word for LED %0d arrived with nothing owed", out_word.out_index);
				mismatch_cnt++;
			end else begin
				want = colors_due.pop_front();
				cmp_field("out_index", want.out_index, out_word.out_index);
				cmp_field("red_out",   want.red_out,   out_word.red_out);
				cmp_field("green_out", want.green_out, out_word.green_out);
				cmp_field("blue_out",  want.blue_out,  out_word.blue_out);
				cmp_field("changed",   want.changed,   out_word.changed);
				cmp_field("refresh",   want.refresh,   out_word.refresh);
				cmp_field("last",      want.last,      out_word.last);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("rgb_led_fade_engine_top verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		logic [PER_W-1:0] per_plan [NUM_PHASES];

		// Directed table, run at the reset tick period of ten milliseconds. Rows with a
		// typed tail follow LED 15 through reset, saturation, a one-tick fade and a fade
		// that starts already on target.
		add_row(tick_word(), 1'b1, tick_tail(8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		add_row(set_word(8'd15, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'd0), 1'b0, '0);
		add_row(tick_word(), 1'b1, tick_tail(8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
		add_row(set_word(8'd15, 8'd0, 8'd0, 8'd0, 16'd0, 16'd10), 1'b0, '0);
		add_row(tick_word(), 1'b1, tick_tail(8'd0, 8'd0, 8'd0, 1'b1, 1'b1));
		add_row(set_word(8'd0, 8'd1, 8'd128, 8'd255, 16'd1023, 16'd0), 1'b0, '0);
		// Indexes past the last LED must be ignored.
		add_row(set_word(8'd16, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'd0), 1'b0, '0);
		add_row(set_word(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'd0), 1'b0, '0);
		// A fade shorter than one tick still takes one tick.
		add_row(set_word(8'd3, 8'd200, 8'd100, 8'd50, 16'd1024, 16'd5), 1'b0, '0);
		// Longest fade: the per-tick step truncates to zero and is forced to one.
		add_row(set_word(8'd5, 8'd255, 8'd0, 8'd170, 16'hFFFF, 16'hFFFF), 1'b0, '0);
		add_row(set_word(8'd6, 8'h55, 8'hAA, 8'h0F, 16'd1024, 16'd40), 1'b0, '0);
		add_row(tick_word(), 1'b0, '0);
		add_row(tick_word(), 1'b0, '0);
		add_row(set_word(8'd15, 8'd0, 8'd0, 8'd0, 16'd0, 16'd20), 1'b0, '0);
		add_row(tick_word(), 1'b1, tick_tail(8'd0, 8'd0, 8'd0, 1'b1, 1'b1));
		// Fade back down from a partly faded color.
		add_row(set_word(8'd5, 8'd0, 8'd0, 8'd0, 16'd1024, 16'd30), 1'b0, '0);
		add_row(set_word(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0);
		add_row(tick_word(), 1'b0, '0);
		add_row(tick_word(), 1'b0, '0);
		add_row(tick_word(), 1'b0, '0);
		add_row(tick_word(), 1'b0, '0);
		add_row(set_word(8'd14, 8'd1, 8'd2, 8'd3, 16'h8000, 16'h8000), 1'b0, '0);
		add_row(tick_word(), 1'b0, '0);

		// Tick periods per phase: the reset value, both ends of the range, a zero period
		// (taken as one), the largest the register holds, a random one and a fixed seven.
		per_plan[0] = PER_RESET;
		per_plan[1] = PER_W'(1);
		per_plan[2] = PER_W'(1000);
		per_plan[3] = '0;
		per_plan[4] = '1;
		per_plan[5] = PER_W'($urandom_range(999, 2));
		per_plan[6] = PER_W'(7);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < dir_word.size(); r++) begin
			send_word(dir_word[r]);
			// Where the tail is typed in, it stands in for the predicted one.
			if (dir_known[r])
				colors_due[colors_due.size() - 1] = dir_tail[r];
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// Every phase after the first starts with a full drain and a new period.
			if (ph != 0)
				write_period(per_plan[ph]);
			for (int k = 0; k < RAND_PER_PH; k++) begin
				// One long back-to-back stretch with neither side idling.
				no_gaps = (ph == 1) && (k < 40);
				send_word(random_word());
			end
			no_gaps = 1'b0;
		end

		in_valid <= 1'b0;
		while (colors_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("rgb_led_fade_engine_top verification clean");
		else
			$display("rgb_led_fade_engine_top verification failed");
		$finish;
	end

endmodule
